### rtl/core/llhm_pkg.sv
// ----------------------------------------------------------------------------
// llhm_pkg
// Shared types and constants of the link and load health monitor: request
// codes, status levels, register indexes, controller states and the command
// bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package llhm_pkg;

	// Request codes carried by req_type.
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_CAN_RX  = 3'd1;
	localparam logic [2:0] REQ_CAN_ERR = 3'd2;
	localparam logic [2:0] REQ_LINK_RX = 3'd3;
	localparam logic [2:0] REQ_CPU     = 3'd4;

	// Status levels shared by all status outputs.
	localparam logic [1:0] LVL_OK   = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_ERR  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_CAN_SILENT   = 3'd0;
	localparam logic [2:0] CFG_LINK_TIMEOUT = 3'd1;
	localparam logic [2:0] CFG_LINK_LATE    = 3'd2;
	localparam logic [2:0] CFG_LOAD_HIGH    = 3'd3;
	localparam logic [2:0] CFG_LOAD_OVER    = 3'd4;
	localparam logic [2:0] CFG_SLOW_HALF    = 3'd5;
	localparam logic [2:0] CFG_FAST_HALF    = 3'd6;
	localparam logic [2:0] CFG_WDG_RESTART  = 3'd7;

	// Field and datapath widths.
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STEPS  = 32;     // one quotient bit of time_ms per cycle
	localparam int CPU_STEPS  = 7;      // load quotient is below 128
	localparam int PROD_W     = 39;     // holds 101 times a 32-bit delta
	localparam logic [15:0] SAT16   = 16'hFFFF;
	localparam logic [6:0]  PCT_FULL = 7'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_PREP,
		ST_DIV,
		ST_FINISH,
		ST_OUTPUT
	} llhm_state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic prep;
		logic step;
		logic cpu_step;
		logic finish;
		logic emit;
	} llhm_cmd_t;

endpackage

### rtl/core/llhm_blink_div.sv
// ----------------------------------------------------------------------------
// llhm_blink_div
// Bit-serial restoring divider of the 32-bit time counter by a 16-bit half
// period. Only the parity of the quotient is kept; it sets the blink level.
// ----------------------------------------------------------------------------
module llhm_blink_div import llhm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        level
);

	logic [31:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic        par_q;
	logic [16:0] trial;
	logic        fits;

	// One long-division step: bring down the next dividend bit and compare.
	always_comb begin
		trial = {rem_q, num_q[31]};
		fits  = trial >= {1'b0, div_q};
	end

	// A half period of zero divides as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= 1'b0;
		end else if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == 16'd0) ? 16'd1 : divisor;
			par_q <= 1'b0;
		end else if (step) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			par_q <= fits;
		end
	end

	// The level is high while the quotient is even.
	assign level = ~par_q;

endmodule

### rtl/core/llhm_datapath.sv
// ----------------------------------------------------------------------------
// llhm_datapath
// Monitor state, configuration registers, load divider, blink dividers and
// the registered result; all but the configuration follow the controller.
// ----------------------------------------------------------------------------
module llhm_datapath import llhm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llhm_cmd_t             cmd,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [2:0]            req_type,
	input  logic [31:0]           total_run,
	input  logic [31:0]           idle_run,
	output logic [1:0]            system_status,
	output logic [1:0]            heartbeat_status,
	output logic [1:0]            can_status,
	output logic [1:0]            link_status,
	output logic [1:0]            cpu_health,
	output logic [6:0]            cpu_load,
	output logic                  led_red,
	output logic                  led_green,
	output logic                  led_blue
);

	// Configuration registers.
	logic [15:0] can_silent_q, link_timeout_q, link_late_q;
	logic [6:0]  load_high_q, load_over_q;
	logic [15:0] slow_half_q, fast_half_q;
	logic        wdg_restart_q;

	// Monitor state.
	logic [31:0] time_ms_q;
	logic [15:0] since_can_q, since_link_q;
	logic        can_rx_seen_q, can_err_seen_q;
	logic [31:0] prev_total_q, prev_idle_q;
	logic [6:0]  load_pct_q;
	logic [1:0]  load_status_q;

	// Captured request and load division work registers.
	logic [2:0]        req_q;
	logic [31:0]       total_q, idle_q;
	logic [31:0]       dt_q;
	logic              di_ge_q;
	logic              load_en_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dsh_q;
	logic [6:0]        quo_q;

	logic [31:0] dt, di;
	logic        cpu_fits;
	logic        slow_lvl, fast_lvl;
	logic [1:0]  hb_lvl, can_lvl, link_lvl, cpu_lvl, sys_lvl;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			can_silent_q   <= 16'd500;
			link_timeout_q <= 16'd100;
			link_late_q    <= 16'd80;
			load_high_q    <= 7'd70;
			load_over_q    <= 7'd85;
			slow_half_q    <= 16'd1000;
			fast_half_q    <= 16'd500;
			wdg_restart_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAN_SILENT:   can_silent_q   <= cfg_data;
				CFG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				CFG_LINK_LATE:    link_late_q    <= cfg_data;
				CFG_LOAD_HIGH:    load_high_q    <= cfg_data[6:0];
				CFG_LOAD_OVER:    load_over_q    <= cfg_data[6:0];
				CFG_SLOW_HALF:    slow_half_q    <= cfg_data;
				CFG_FAST_HALF:    fast_half_q    <= cfg_data;
				CFG_WDG_RESTART:  wdg_restart_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			total_q <= total_run;
			idle_q  <= idle_run;
		end
	end

	// Counter deltas against the previous CPU sample.
	always_comb begin
		dt = total_q - prev_total_q;
		di = idle_q - prev_idle_q;
	end

	// Event update of the monitor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_ms_q      <= '0;
			since_can_q    <= '0;
			since_link_q   <= '0;
			can_rx_seen_q  <= 1'b0;
			can_err_seen_q <= 1'b0;
			prev_total_q   <= '0;
			prev_idle_q    <= '0;
			load_en_q      <= 1'b0;
		end else if (cmd.update) begin
			load_en_q <= 1'b0;
			unique case (req_q)
				REQ_TICK: begin
					time_ms_q    <= time_ms_q + 32'd1;
					since_can_q  <= (since_can_q == SAT16) ? SAT16 : since_can_q + 16'd1;
					since_link_q <= (since_link_q == SAT16) ? SAT16 : since_link_q + 16'd1;
				end
				REQ_CAN_RX: begin
					since_can_q   <= '0;
					can_rx_seen_q <= 1'b1;
				end
				REQ_CAN_ERR: begin
					can_err_seen_q <= 1'b1;
				end
				REQ_LINK_RX: begin
					since_link_q <= '0;
				end
				REQ_CPU: begin
					load_en_q    <= (prev_total_q != 32'd0) && (dt != 32'd0);
					prev_total_q <= total_q;
					prev_idle_q  <= idle_q;
				end
				default: ;
			endcase
		end
	end

	// Scaled idle delta; an idle share of one or more means zero load.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			dt_q    <= dt;
			di_ge_q <= di >= dt;
			prod_q  <= PROD_W'(di) * PROD_W'(PCT_FULL);
		end
	end

	// Load division: ceil(100 * di / dt), one quotient bit per step.
	assign cpu_fits = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= prod_q + PROD_W'(dt_q) - PROD_W'(1);
			dsh_q <= {1'b0, dt_q, 6'b0};
			quo_q <= '0;
		end else if (cmd.cpu_step) begin
			rem_q <= cpu_fits ? rem_q - dsh_q : rem_q;
			dsh_q <= {1'b0, dsh_q[PROD_W-1:1]};
			quo_q <= {quo_q[5:0], cpu_fits};
		end
	end

	// Blink phase dividers for the slow and fast half periods.
	llhm_blink_div u_slow_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.prep),
		.step     (cmd.step),
		.dividend (time_ms_q),
		.divisor  (slow_half_q),
		.level    (slow_lvl)
	);

	llhm_blink_div u_fast_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.prep),
		.step     (cmd.step),
		.dividend (time_ms_q),
		.divisor  (fast_half_q),
		.level    (fast_lvl)
	);

	// New load percentage, kept on a first sample or a zero total delta.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pct_q <= '0;
		end else if (cmd.finish && load_en_q) begin
			if (di_ge_q || quo_q >= PCT_FULL)
				load_pct_q <= '0;
			else
				load_pct_q <= PCT_FULL - quo_q;
		end
	end

	// Status levels after the update.
	always_comb begin
		hb_lvl = wdg_restart_q ? LVL_ERR : LVL_OK;

		if (can_rx_seen_q && since_can_q > can_silent_q)
			can_lvl = LVL_ERR;
		else if (can_err_seen_q)
			can_lvl = LVL_WARN;
		else
			can_lvl = LVL_OK;

		if (since_link_q > link_timeout_q)
			link_lvl = LVL_ERR;
		else if (since_link_q > link_late_q)
			link_lvl = LVL_WARN;
		else
			link_lvl = LVL_OK;

		cpu_lvl = load_status_q;
		if (req_q == REQ_CPU) begin
			if (load_pct_q > load_over_q)
				cpu_lvl = LVL_ERR;
			else if (load_pct_q > load_high_q)
				cpu_lvl = LVL_WARN;
			else
				cpu_lvl = LVL_OK;
		end

		sys_lvl = hb_lvl;
		if (can_lvl > sys_lvl)
			sys_lvl = can_lvl;
		if (link_lvl > sys_lvl)
			sys_lvl = link_lvl;
		if (cpu_lvl > sys_lvl)
			sys_lvl = cpu_lvl;
	end

	// CPU status is held between samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_status_q <= LVL_OK;
		end else if (cmd.emit) begin
			load_status_q <= cpu_lvl;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			system_status    <= sys_lvl;
			heartbeat_status <= hb_lvl;
			can_status       <= can_lvl;
			link_status      <= link_lvl;
			cpu_health       <= cpu_lvl;
			cpu_load         <= load_pct_q;
			led_red          <= hb_lvl == LVL_ERR;
			led_green        <= (link_lvl == LVL_OK) ? 1'b1 :
			                    (link_lvl == LVL_WARN) ? slow_lvl : fast_lvl;
			led_blue         <= (cpu_lvl == LVL_OK) ? 1'b0 :
			                    (cpu_lvl == LVL_WARN) ? slow_lvl : fast_lvl;
		end
	end

endmodule

### rtl/core/llhm_ctrl.sv
// ----------------------------------------------------------------------------
// llhm_ctrl
// Sequencer of the monitor: takes one request, steps the datapath through
// update, division and finish, and hands the result to the output register.
// ----------------------------------------------------------------------------
module llhm_ctrl import llhm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output llhm_cmd_t cmd
);

	llhm_state_t state_q, state_d;
	logic [4:0]  count_q;
	logic        out_valid_q;
	logic        out_free;
	logic        div_last;

	assign out_free = !out_valid_q || !out_stall;
	assign div_last = count_q == 5'(DIV_STEPS - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (div_last) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUTPUT;
			ST_OUTPUT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.update   = state_q == ST_UPDATE;
		cmd.prep     = state_q == ST_PREP;
		cmd.step     = state_q == ST_DIV;
		cmd.cpu_step = (state_q == ST_DIV) && (count_q < 5'(CPU_STEPS));
		cmd.finish   = state_q == ST_FINISH;
		cmd.emit     = (state_q == ST_OUTPUT) && out_free;
	end

	// State, step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP)
				count_q <= '0;
			else if (state_q == ST_DIV)
				count_q <= count_q + 5'd1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

### rtl/core/link_and_load_health_monitor_unit.sv
// ----------------------------------------------------------------------------
// link_and_load_health_monitor_unit
// Health monitor for CAN traffic, link traffic and CPU load.
//
// Input channel (in_valid / in_stall): one request per event: a millisecond
// tick, CAN receive, CAN error, link receive or CPU sample with total and
// idle run counters. Every request gives exactly one result on the output
// channel (out_valid / out_stall): the four statuses, their maximum, the
// last CPU load and the three LED levels.
// An accepted request is worked through the states update,
// setup, 32 steps of the bit-serial blink dividers (the CPU load division
// runs in the first 7 of them), finish and output. One request is worked at
// a time, so a new one is taken only once the last has left the output state.
// The finished result sits in an output register; while the receiver stalls
// it holds, the next request can still be accepted and worked, and its result
// waits in the output state until the register is free.
// Reset clears all monitor state and loads the configuration defaults; no
// result is pending after reset. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module link_and_load_health_monitor_unit import llhm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            req_type,
	input  logic [31:0]           total_run,
	input  logic [31:0]           idle_run,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            system_status,
	output logic [1:0]            heartbeat_status,
	output logic [1:0]            can_status,
	output logic [1:0]            link_status,
	output logic [1:0]            cpu_health,
	output logic [6:0]            cpu_load,
	output logic                  led_red,
	output logic                  led_green,
	output logic                  led_blue
);

	llhm_cmd_t cmd;

	// Sequencer.
	llhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// State, arithmetic and result register.
	llhm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.total_run        (total_run),
		.idle_run         (idle_run),
		.system_status    (system_status),
		.heartbeat_status (heartbeat_status),
		.can_status       (can_status),
		.link_status      (link_status),
		.cpu_health       (cpu_health),
		.cpu_load         (cpu_load),
		.led_red          (led_red),
		.led_green        (led_green),
		.led_blue         (led_blue)
	);

endmodule
